@@ rtl/erst_pkg.sv @@
// Shared types and constants for the expert residency SLRU tracker.
// Depends on nothing; every other file imports it.
`timescale 1ns / 1ps
package erst_pkg;

    localparam int LAYER_W    = 6;
    localparam int EXPERT_W   = 8;
    localparam int KEY_W      = LAYER_W + EXPERT_W;
    localparam int BUDGET_W   = 6;
    localparam int EPL_W      = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    // Key range limits for accesses
    localparam int MAX_LAYERS  = 64;
    localparam int MAX_EXPERTS = 256;

    // Register reset values
    localparam logic                  POLICY_RST = 1'b0;
    localparam logic [BUDGET_W-1:0]   BUDGET_RST = 6'd16;
    localparam logic [EPL_W-1:0]      EPL_RST    = 9'd8;

    // Reciprocal of 5 for the protected capacity: x/5 == (x*205)>>10 for x < 1024
    localparam int RECIP5     = 205;
    localparam int RECIP5_SH  = 10;

    typedef enum logic [2:0] {
        ACT_HIT     = 3'd0,
        ACT_MISS    = 3'd1,
        ACT_EVICT   = 3'd2,
        ACT_IGNORED = 3'd3,
        ACT_NONE    = 3'd4
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_POLICY  = 2'd0,
        REG_BUDGET  = 2'd1,
        REG_EXPERTS = 2'd2
    } cfg_reg_t;

    localparam logic REQ_ACCESS = 1'b0;
    localparam logic REQ_SWEEP  = 1'b1;

endpackage

@@ rtl/erst_req_if.sv @@
// Request channel of the residency tracker: valid/ready plus one request word.
// Depends on erst_pkg.
`timescale 1ns / 1ps
interface erst_req_if;
    import erst_pkg::*;

    logic                valid;
    logic                ready;
    logic                req_type;
    logic [LAYER_W-1:0]  layer;
    logic [EXPERT_W-1:0] expert;

    modport source (output valid, req_type, layer, expert, input ready);
    modport sink   (input valid, req_type, layer, expert, output ready);
endinterface

@@ rtl/erst_rsp_if.sv @@
// Result channel of the residency tracker: valid/ready plus one result word.
// Depends on erst_pkg.
`timescale 1ns / 1ps
interface erst_rsp_if;
    import erst_pkg::*;

    logic                valid;
    logic                ready;
    action_t             action;
    logic [LAYER_W-1:0]  out_layer;
    logic [EXPERT_W-1:0] out_expert;
    logic                last;

    modport source (output valid, action, out_layer, out_expert, last, input ready);
    modport sink   (input valid, action, out_layer, out_expert, last, output ready);
endinterface

@@ rtl/erst_cfg_if.sv @@
// Configuration write channel: valid/ready, register index and write data.
// Depends on erst_pkg.
`timescale 1ns / 1ps
interface erst_cfg_if;
    import erst_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/expert_residency_slru_tracker_unit.sv @@
// Top level of the expert residency tracker (LRU / segmented LRU).
// Depends on erst_pkg, erst_req_if, erst_rsp_if and erst_cfg_if.
`timescale 1ns / 1ps
// Tracks which (layer, expert) keys are resident in a store of TRACK_DEPTH slots.
// Keys sit in a one-port-read, one-port-write synchronous memory; recency ranks,
// segment bits and valid bits sit in a row of per-slot cells that shift all ranks
// together. An access scans the key memory one slot a cycle; a miss then fills a
// free slot, a hit unlinks and pushes back the key, a promotion in segmented mode
// adds a capacity check and may demote the protected tail, and a miss on a full
// store first evicts a tail. A sweep evicts probation tails, or demotes the
// protected tail when probation is empty, until the budget holds, then finishes.
// Output back-pressure adds its stall cycles to every word.
// One request is worked at a time; a new request is taken while the last result
// still waits in the output register. No clearing pass is needed after reset.
module expert_residency_slru_tracker_unit #(
    parameter int TRACK_DEPTH = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    erst_req_if.sink   req,
    erst_rsp_if.source rsp,
    erst_cfg_if.sink   cfg
);
    import erst_pkg::*;

    localparam int IW   = $clog2(TRACK_DEPTH);
    localparam int CW   = $clog2(TRACK_DEPTH + 1);
    localparam int CMPW = (CW + 1 > 7) ? CW + 1 : 7;

    typedef enum logic [10:0] {
        S_IDLE    = 11'b000_0000_0001,
        S_SCAN    = 11'b000_0000_0010,
        S_ACC     = 11'b000_0000_0100,
        S_HPUSH   = 11'b000_0000_1000,
        S_HCHK    = 11'b000_0001_0000,
        S_DPUSH   = 11'b000_0010_0000,
        S_EVICT_M = 11'b000_0100_0000,
        S_MISS_IN = 11'b000_1000_0000,
        S_SW      = 11'b001_0000_0000,
        S_EVICT_S = 11'b010_0000_0000,
        S_EMIT    = 11'b100_0000_0000
    } state_t;

    // Configuration registers
    logic                policy_reg;
    logic [BUDGET_W-1:0] budget_reg;
    logic [EPL_W-1:0]    epl_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= POLICY_RST;
            budget_reg <= BUDGET_RST;
            epl_reg    <= EPL_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_POLICY:  policy_reg <= cfg.data[0];
                REG_BUDGET:  budget_reg <= cfg.data[BUDGET_W-1:0];
                REG_EXPERTS: epl_reg    <= cfg.data;
                default:     ;
            endcase
        end
    end

    // Protected capacity = budget*4/5
    logic [15:0]         cap_prod;
    logic [BUDGET_W-1:0] cap;
    assign cap_prod = 16'({budget_reg, 2'b00}) * 16'(RECIP5);
    assign cap      = cap_prod[RECIP5_SH +: BUDGET_W];

    // Control registers
    state_t              state_reg, state_next;
    logic [LAYER_W-1:0]  layer_reg, layer_next;
    logic [EXPERT_W-1:0] expert_reg, expert_next;
    logic                sweep_reg, sweep_next;
    logic [IW:0]         scan_idx_reg, scan_idx_next;
    logic                cmp_vld_reg, cmp_vld_next;
    logic [IW-1:0]       cmp_idx_reg, cmp_idx_next;
    logic                hit_reg, hit_next;
    logic [IW-1:0]       hit_idx_reg, hit_idx_next;
    logic                was_prot_reg, was_prot_next;
    logic [IW-1:0]       victim_reg, victim_next;
    logic                evicted_reg, evicted_next;
    action_t             act_reg, act_next;

    // Output register
    logic                out_valid_reg, out_valid_next;
    action_t             out_act_reg, out_act_next;
    logic [LAYER_W-1:0]  out_layer_reg, out_layer_next;
    logic [EXPERT_W-1:0] out_expert_reg, out_expert_next;
    logic                out_last_reg, out_last_next;
    logic                out_free;

    assign out_free       = !out_valid_reg || rsp.ready;
    assign rsp.valid      = out_valid_reg;
    assign rsp.action     = out_act_reg;
    assign rsp.out_layer  = out_layer_reg;
    assign rsp.out_expert = out_expert_reg;
    assign rsp.last       = out_last_reg;
    assign req.ready      = (state_reg == S_IDLE);

    // Slot cells
    logic [TRACK_DEPTH-1:0] valid_reg;
    logic [TRACK_DEPTH-1:0] prot_reg;
    logic [IW-1:0]          rank_reg [TRACK_DEPTH];
    logic [CW-1:0]          prot_cnt_reg, prob_cnt_reg;

    logic          op_unlink, op_push, op_prot;
    logic [IW-1:0] op_idx;
    logic          u_seg;
    logic [IW-1:0] u_rank;

    assign u_seg  = prot_reg[op_idx];
    assign u_rank = rank_reg[op_idx];

    // Key memory
    logic [KEY_W-1:0] key_mem [TRACK_DEPTH];
    logic [KEY_W-1:0] rd_data_reg;
    logic             mem_we, rd_en;
    logic [IW-1:0]    mem_waddr, rd_addr;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            key_mem[mem_waddr] <= {layer_reg, expert_reg};
        end
        if (rd_en)
        begin
            rd_data_reg <= key_mem[rd_addr];
        end
    end

    // Segment tails (rank == count-1) and first free slot
    logic          tail0_ok, tail1_ok, free_ok;
    logic [IW-1:0] tail0_idx, tail1_idx, free_idx;

    always_comb
    begin
        tail0_ok  = 1'b0;
        tail1_ok  = 1'b0;
        free_ok   = 1'b0;
        tail0_idx = '0;
        tail1_idx = '0;
        free_idx  = '0;
        for (int j = TRACK_DEPTH - 1; j >= 0; j--)
        begin
            if (valid_reg[j] && !prot_reg[j]
                && CMPW'(rank_reg[j]) + CMPW'(1) == CMPW'(prob_cnt_reg))
            begin
                tail0_ok  = 1'b1;
                tail0_idx = IW'(j);
            end
            if (valid_reg[j] && prot_reg[j]
                && CMPW'(rank_reg[j]) + CMPW'(1) == CMPW'(prot_cnt_reg))
            begin
                tail1_ok  = 1'b1;
                tail1_idx = IW'(j);
            end
            if (!valid_reg[j])
            begin
                free_ok  = 1'b1;
                free_idx = IW'(j);
            end
        end
    end

    logic [CMPW-1:0] total;
    logic            key_match, ignored;
    assign total     = CMPW'(prot_cnt_reg) + CMPW'(prob_cnt_reg);
    assign key_match = cmp_vld_reg && valid_reg[cmp_idx_reg]
                       && rd_data_reg == {layer_reg, expert_reg};
    assign ignored   = budget_reg == '0 || {1'b0, req.expert} >= epl_reg
                       || int'(req.expert) >= MAX_EXPERTS
                       || int'(req.layer) >= MAX_LAYERS;

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        layer_next      = layer_reg;
        expert_next     = expert_reg;
        sweep_next      = sweep_reg;
        scan_idx_next   = scan_idx_reg;
        cmp_vld_next    = 1'b0;
        cmp_idx_next    = cmp_idx_reg;
        hit_next        = hit_reg;
        hit_idx_next    = hit_idx_reg;
        was_prot_next   = was_prot_reg;
        victim_next     = victim_reg;
        evicted_next    = evicted_reg;
        act_next        = act_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_act_next    = out_act_reg;
        out_layer_next  = out_layer_reg;
        out_expert_next = out_expert_reg;
        out_last_next   = out_last_reg;
        op_unlink       = 1'b0;
        op_push         = 1'b0;
        op_prot         = 1'b0;
        op_idx          = '0;
        mem_we          = 1'b0;
        mem_waddr       = '0;
        rd_en           = 1'b0;
        rd_addr         = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    layer_next    = req.layer;
                    expert_next   = req.expert;
                    sweep_next    = req.req_type;
                    hit_next      = 1'b0;
                    evicted_next  = 1'b0;
                    scan_idx_next = '0;
                    if (req.req_type == REQ_SWEEP)
                    begin
                        state_next = S_SW;
                    end
                    else if (ignored)
                    begin
                        act_next   = ACT_IGNORED;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end

            // Tag scan, one slot a cycle, compare in the cycle after the read
            S_SCAN:
            begin
                if (scan_idx_reg < (IW + 1)'(TRACK_DEPTH))
                begin
                    rd_en         = 1'b1;
                    rd_addr       = scan_idx_reg[IW-1:0];
                    scan_idx_next = scan_idx_reg + 1'b1;
                    cmp_vld_next  = 1'b1;
                    cmp_idx_next  = scan_idx_reg[IW-1:0];
                end
                if (key_match)
                begin
                    hit_next     = 1'b1;
                    hit_idx_next = cmp_idx_reg;
                end
                if (cmp_vld_reg && cmp_idx_reg == IW'(TRACK_DEPTH - 1))
                begin
                    state_next = S_ACC;
                end
            end

            S_ACC:
            begin
                if (hit_reg)
                begin
                    was_prot_next = prot_reg[hit_idx_reg];
                    op_unlink     = 1'b1;
                    op_idx        = hit_idx_reg;
                    state_next    = S_HPUSH;
                end
                else if (free_ok)
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = free_idx;
                    op_push    = 1'b1;
                    op_idx     = free_idx;
                    act_next   = ACT_MISS;
                    state_next = S_EMIT;
                end
                else
                begin
                    victim_next = tail0_ok ? tail0_idx : (tail1_ok ? tail1_idx : '0);
                    rd_en       = 1'b1;
                    rd_addr     = victim_next;
                    state_next  = S_EVICT_M;
                end
            end

            S_HPUSH:
            begin
                op_push  = 1'b1;
                op_idx   = hit_idx_reg;
                op_prot  = policy_reg;
                act_next = ACT_HIT;
                state_next = (policy_reg && !was_prot_reg) ? S_HCHK : S_EMIT;
            end

            // Protected overflow: demote its tail
            S_HCHK:
            begin
                if (CMPW'(prot_cnt_reg) > CMPW'(cap))
                begin
                    victim_next = tail1_idx;
                    op_unlink   = 1'b1;
                    op_idx      = tail1_idx;
                    state_next  = S_DPUSH;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end

            S_DPUSH:
            begin
                op_push    = 1'b1;
                op_idx     = victim_reg;
                state_next = sweep_reg ? S_SW : S_EMIT;
            end

            S_EVICT_M:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_act_next    = ACT_EVICT;
                    out_layer_next  = rd_data_reg[KEY_W-1 -: LAYER_W];
                    out_expert_next = rd_data_reg[EXPERT_W-1:0];
                    out_last_next   = 1'b0;
                    op_unlink       = 1'b1;
                    op_idx          = victim_reg;
                    state_next      = S_MISS_IN;
                end
            end

            S_MISS_IN:
            begin
                mem_we     = 1'b1;
                mem_waddr  = victim_reg;
                op_push    = 1'b1;
                op_idx     = victim_reg;
                act_next   = ACT_MISS;
                state_next = S_EMIT;
            end

            // Sweep loop: evict probation tails, demote protected tail when empty
            S_SW:
            begin
                if (budget_reg != '0 && total > CMPW'(budget_reg)
                    && (prob_cnt_reg != '0 || prot_cnt_reg != '0))
                begin
                    if (prob_cnt_reg != '0)
                    begin
                        victim_next = tail0_idx;
                        rd_en       = 1'b1;
                        rd_addr     = tail0_idx;
                        state_next  = S_EVICT_S;
                    end
                    else
                    begin
                        victim_next = tail1_idx;
                        op_unlink   = 1'b1;
                        op_idx      = tail1_idx;
                        state_next  = S_DPUSH;
                    end
                end
                else if (evicted_reg)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    act_next   = ACT_NONE;
                    state_next = S_EMIT;
                end
            end

            S_EVICT_S:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_act_next    = ACT_EVICT;
                    out_layer_next  = rd_data_reg[KEY_W-1 -: LAYER_W];
                    out_expert_next = rd_data_reg[EXPERT_W-1:0];
                    out_last_next   = total <= CMPW'(budget_reg) + CMPW'(1);
                    op_unlink       = 1'b1;
                    op_idx          = victim_reg;
                    evicted_next    = 1'b1;
                    state_next      = S_SW;
                end
            end

            // Final word of the request
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_act_next    = act_reg;
                    out_layer_next  = (act_reg == ACT_NONE) ? '0 : layer_reg;
                    out_expert_next = (act_reg == ACT_NONE) ? '0 : expert_reg;
                    out_last_next   = 1'b1;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control and output registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cmp_vld_reg   <= 1'b0;
            hit_reg       <= 1'b0;
            evicted_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cmp_vld_reg   <= cmp_vld_next;
            hit_reg       <= hit_next;
            evicted_reg   <= evicted_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        layer_reg      <= layer_next;
        expert_reg     <= expert_next;
        sweep_reg      <= sweep_next;
        scan_idx_reg   <= scan_idx_next;
        cmp_idx_reg    <= cmp_idx_next;
        hit_idx_reg    <= hit_idx_next;
        was_prot_reg   <= was_prot_next;
        victim_reg     <= victim_next;
        act_reg        <= act_next;
        out_act_reg    <= out_act_next;
        out_layer_reg  <= out_layer_next;
        out_expert_reg <= out_expert_next;
        out_last_reg   <= out_last_next;
    end

    // Slot cells: unlink closes the rank gap, push shifts the segment back
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            prot_reg     <= '0;
            prot_cnt_reg <= '0;
            prob_cnt_reg <= '0;
            for (int j = 0; j < TRACK_DEPTH; j++)
            begin
                rank_reg[j] <= '0;
            end
        end
        else
        begin
            for (int j = 0; j < TRACK_DEPTH; j++)
            begin
                if (op_unlink)
                begin
                    if (IW'(j) == op_idx)
                    begin
                        valid_reg[j] <= 1'b0;
                    end
                    else if (valid_reg[j] && prot_reg[j] == u_seg && rank_reg[j] > u_rank)
                    begin
                        rank_reg[j] <= rank_reg[j] - 1'b1;
                    end
                end
                else if (op_push)
                begin
                    if (IW'(j) == op_idx)
                    begin
                        valid_reg[j] <= 1'b1;
                        prot_reg[j]  <= op_prot;
                        rank_reg[j]  <= '0;
                    end
                    else if (valid_reg[j] && prot_reg[j] == op_prot)
                    begin
                        rank_reg[j] <= rank_reg[j] + 1'b1;
                    end
                end
            end
            if (op_unlink)
            begin
                if (u_seg && prot_cnt_reg != '0)
                begin
                    prot_cnt_reg <= prot_cnt_reg - 1'b1;
                end
                else if (!u_seg && prob_cnt_reg != '0)
                begin
                    prob_cnt_reg <= prob_cnt_reg - 1'b1;
                end
            end
            else if (op_push)
            begin
                if (op_prot)
                begin
                    prot_cnt_reg <= prot_cnt_reg + 1'b1;
                end
                else
                begin
                    prob_cnt_reg <= prob_cnt_reg + 1'b1;
                end
            end
        end
    end

    // Checks
    a_cnt_match: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == int'(prot_cnt_reg) + int'(prob_cnt_reg))
        else $error("segment counts disagree with valid slots");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(prot_cnt_reg) + int'(prob_cnt_reg) <= TRACK_DEPTH)
        else $error("resident count exceeds store depth");

    a_no_wr_scan: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN |-> !mem_we)
        else $error("key memory written during tag scan");

    a_one_op: assert property (@(posedge clk) disable iff (!rst_n)
        !(op_unlink && op_push))
        else $error("unlink and push in the same cycle");

endmodule

@@ test/erst_tracker_checker.sv @@
// Scoreboard for the expert residency tracker: watches the request, config and result
// channels, predicts the result words and compares them. Depends on erst_pkg and the
// erst_req_if, erst_rsp_if and erst_cfg_if interfaces.
`timescale 1ns / 1ps
module erst_tracker_checker
    import erst_pkg::*;
#(
    parameter int DEPTH = 32
) (
    input  logic clk,
    input  logic rst_n,
    erst_req_if  req,
    erst_rsp_if  rsp,
    erst_cfg_if  cfg,
    output int   mismatches,
    output int   pending
);

    typedef struct {
        action_t             act;
        logic [LAYER_W-1:0]  lay;
        logic [EXPERT_W-1:0] exp_id;
        logic                last;
    } result_word_t;

    // Shadow copy of the store and the registers
    logic [LAYER_W-1:0]  key_layer [DEPTH];
    logic [EXPERT_W-1:0] key_expert[DEPTH];
    bit                  resident  [DEPTH];
    bit                  in_prot   [DEPTH];
    int                  recency   [DEPTH];
    int                  prot_cnt;
    int                  prob_cnt;
    bit                  slru_on;
    int                  budget_v;
    int                  epl_v;

    result_word_t burst[$];
    result_word_t expected_words[$];

    task automatic report(input string what, input int got, input int want);
        $display("[%0t] MISMATCH %s: got %0d expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    task automatic add_word(input action_t a, input int l, input int e);
        result_word_t w;
        w.act    = a;
        w.lay    = l[LAYER_W-1:0];
        w.exp_id = e[EXPERT_W-1:0];
        w.last   = 1'b0;
        burst = {burst, w};
    endtask

    task automatic unlink(input int i);
        for (int j = 0; j < DEPTH; j++)
            if (j != i && resident[j] && in_prot[j] == in_prot[i] && recency[j] > recency[i])
                recency[j]--;
        if (in_prot[i]) begin
            if (prot_cnt > 0) prot_cnt--;
        end else begin
            if (prob_cnt > 0) prob_cnt--;
        end
        resident[i] = 1'b0;
    endtask

    task automatic link_front(input int i, input bit p);
        for (int j = 0; j < DEPTH; j++)
            if (j != i && resident[j] && in_prot[j] == p)
                recency[j]++;
        resident[i] = 1'b1;
        in_prot[i]  = p;
        recency[i]  = 0;
        if (p) prot_cnt++;
        else   prob_cnt++;
    endtask

    function automatic int tail_of(input bit p);
        int best;
        best = -1;
        for (int j = 0; j < DEPTH; j++)
            if (resident[j] && in_prot[j] == p && (best < 0 || recency[j] > recency[best]))
                best = j;
        return best;
    endfunction

    task automatic demote_tail();
        int t;
        t = tail_of(1'b1);
        if (t >= 0)
        begin
            unlink(t);
            link_front(t, 1'b0);
        end
    endtask

    task automatic evict(input int i);
        add_word(ACT_EVICT, key_layer[i], key_expert[i]);
        unlink(i);
    endtask

    task automatic access_key(input int l, input int e);
        int  hit;
        int  slot;
        bit  was_prot;
        hit  = -1;
        slot = -1;
        for (int j = 0; j < DEPTH; j++)
            if (resident[j] && key_layer[j] == l && key_expert[j] == e)
                hit = j;
        if (hit >= 0)
        begin
            was_prot = in_prot[hit];
            unlink(hit);
            if (!slru_on)
                link_front(hit, 1'b0);
            else
            begin
                link_front(hit, 1'b1);
                // fresh promotion may overflow the protected segment
                if (!was_prot && prot_cnt > budget_v * 4 / 5)
                    demote_tail();
            end
            add_word(ACT_HIT, l, e);
            return;
        end
        for (int j = 0; j < DEPTH; j++)
            if (!resident[j] && slot < 0)
                slot = j;
        // full store: drop probation tail, else protected tail
        if (slot < 0)
        begin
            slot = tail_of(1'b0);
            if (slot < 0) slot = tail_of(1'b1);
            if (slot < 0) slot = 0;
            evict(slot);
        end
        key_layer[slot]  = l[LAYER_W-1:0];
        key_expert[slot] = e[EXPERT_W-1:0];
        link_front(slot, 1'b0);
        add_word(ACT_MISS, l, e);
    endtask

    task automatic sweep();
        int guard;
        int t;
        guard = 0;
        if (budget_v == 0) return;
        while (prot_cnt + prob_cnt > budget_v && guard < 4 * DEPTH)
        begin
            guard++;
            if (prob_cnt > 0)
            begin
                t = tail_of(1'b0);
                if (t < 0) break;
                evict(t);
            end
            else if (prot_cnt > 0)
                demote_tail();
            else
                break;
        end
    endtask

    task automatic predict_request(input logic rt, input int l, input int e);
        burst.delete();
        if (rt == REQ_ACCESS)
        begin
            if (budget_v == 0 || e >= epl_v || e >= MAX_EXPERTS || l >= MAX_LAYERS)
                add_word(ACT_IGNORED, l, e);
            else
                access_key(l, e);
        end
        else
        begin
            sweep();
            if (burst.size() == 0)
                add_word(ACT_NONE, 0, 0);
        end
        burst[burst.size()-1].last = 1'b1;
        foreach (burst[k])
            expected_words = {expected_words, burst[k]};
    endtask

    // Observe all three channels at each edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < DEPTH; j++)
            begin
                resident[j] = 1'b0;
                in_prot[j]  = 1'b0;
                recency[j]  = 0;
            end
            prot_cnt   = 0;
            prob_cnt   = 0;
            slru_on    = POLICY_RST;
            budget_v   = BUDGET_RST;
            epl_v      = EPL_RST;
            mismatches = 0;
            expected_words.delete();
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg_reg_t'(cfg.index))
                    REG_POLICY:  slru_on  = cfg.data[0];
                    REG_BUDGET:  budget_v = cfg.data[BUDGET_W-1:0];
                    REG_EXPERTS: epl_v    = cfg.data[EPL_W-1:0];
                    default: ;
                endcase
            end
            if (rsp.valid && rsp.ready)
            begin
                if (expected_words.size() == 0)
                    report("unexpected word, action", rsp.action, -1);
                else
                begin
                    result_word_t w;
                    w = expected_words.pop_front();
                    if (rsp.action !== w.act)       report("action", rsp.action, w.act);
                    if (rsp.out_layer !== w.lay)    report("out_layer", rsp.out_layer, w.lay);
                    if (rsp.out_expert !== w.exp_id)
                        report("out_expert", rsp.out_expert, w.exp_id);
                    if (rsp.last !== w.last)        report("last", rsp.last, w.last);
                end
            end
            if (req.valid && req.ready)
                predict_request(req.req_type, req.layer, req.expert);
        end
        pending = expected_words.size();
    end

endmodule

@@ test/tb_expert_residency_slru_tracker_unit.sv @@
// Top of the residency tracker testbench: clock, reset, stimulus, flow control, verdict.
// Depends on erst_pkg, the channel interfaces, the tracker RTL and erst_tracker_checker.
`timescale 1ns / 1ps
module tb_expert_residency_slru_tracker_unit;
    import erst_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_WAIT  = 80;

    logic clk;
    logic rst_n;
    int   mismatches;
    int   pending;
    int   cycles;
    int   sent;
    int   phases;
    bit   calm;
    bit   hold_rsp;

    erst_req_if req ();
    erst_rsp_if rsp ();
    erst_cfg_if cfg ();

    expert_residency_slru_tracker_unit #(.TRACK_DEPTH(32)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg)
    );

    erst_tracker_checker #(.DEPTH(32)) scoreboard (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .rsp        (rsp),
        .cfg        (cfg),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always #5 clk = ~clk;

    // Run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Result side: random stalls, suspended while hold_rsp is up
    initial
    begin
        int gap;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            gap = calm ? 0 : $urandom_range(0, 11);
            if (gap > 0 || hold_rsp)
            begin
                rsp.ready <= 1'b0;
                repeat (gap) @(posedge clk);
                while (hold_rsp) @(posedge clk);
            end
            rsp.ready <= 1'b1;
            do @(posedge clk); while (!rsp.valid);
        end
    end

    // Long receiver stall partway through, so the block backs up
    initial
    begin
        wait (sent == 200);
        hold_rsp = 1'b1;
        repeat (400) @(posedge clk);
        hold_rsp = 1'b0;
    end

    // One request word; valid stays high into the next word when there is no gap
    task automatic send(input logic rt, input int l, input int e);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid    <= 1'b1;
        req.req_type <= rt;
        req.layer    <= l[LAYER_W-1:0];
        req.expert   <= e[EXPERT_W-1:0];
        do @(posedge clk); while (!req.ready);
        sent++;
    endtask

    task automatic access(input int l, input int e);
        send(REQ_ACCESS, l, e);
    endtask

    // Wait until every predicted word has come back and the block is idle
    task automatic settle();
        req.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input int val);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= val[CFG_DATA_W-1:0];
        do @(posedge clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
    endtask

    task automatic configure(input int mode, input int bud, input int epl);
        settle();
        write_reg(REG_POLICY, mode);
        write_reg(REG_BUDGET, bud);
        write_reg(REG_EXPERTS, epl);
        phases++;
    endtask

    // Mostly accesses over a small key pool, plus sweeps and full-range noise
    task automatic random_item(input int epl);
        int r;
        int pool;
        r    = $urandom_range(0, 99);
        pool = (epl < 12) ? epl : 12;
        if (r < 12)
            send(REQ_SWEEP, $urandom_range(0, 63), $urandom_range(0, 255));
        else if (r < 22)
            access($urandom_range(0, 63), $urandom_range(0, 255));
        else if (r < 40)
            access($urandom_range(0, 3), $urandom_range(0, epl - 1));
        else
            access($urandom_range(0, 3), $urandom_range(0, pool - 1));
    endtask

    initial
    begin
        int modes [8] = '{0, 1, 1, 0, 1, 1, 1, 0};
        int buds  [8] = '{16, 32, 1, 32, 5, 0, 20, 2};
        int epls  [8] = '{8, 256, 1, 256, 16, 4, 40, 3};
        clk       = 1'b0;
        rst_n     = 1'b0;
        cycles    = 0;
        sent      = 0;
        phases    = 0;
        calm      = 1'b0;
        hold_rsp  = 1'b0;
        req.valid <= 1'b0;
        req.req_type <= REQ_ACCESS;
        req.layer <= '0;
        req.expert <= '0;
        rsp.ready <= 1'b0;
        cfg.valid <= 1'b0;
        cfg.index <= REG_POLICY;
        cfg.data  <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset settings, key extremes, ignored ids, empty sweep
        access(0, 0);
        access(63, 7);
        access(0, 0);
        access(5, 8);
        access(63, 255);
        send(REQ_SWEEP, 63, 255);

        // Segmented mode, new keys and promotions
        configure(1, 32, 256);
        for (int k = 0; k < 8; k++) access(k, 255 - k);
        access(0, 255);
        access(1, 254);
        // budget below residents: sweep evicts probation tails
        configure(1, 2, 256);
        send(REQ_SWEEP, 0, 0);
        // capacity zero: hits on a key that is already protected
        configure(1, 1, 256);
        access(1, 254);
        access(1, 254);
        // disabled tracking
        configure(0, 0, 1);
        access(0, 0);
        send(REQ_SWEEP, 0, 0);
        // new keys into probation beside the protected ones
        configure(1, 32, 256);
        for (int k = 0; k < 4; k++) access(k, 200);

        // Random phases across settings
        for (int p = 0; p < 8; p++)
        begin
            configure(modes[p], buds[p], epls[p]);
            calm = (p % 3 == 2);
            for (int k = 0; k < 55; k++) random_item(epls[p]);
            // lower the budget without clearing, then sweep
            configure(modes[p], buds[p] / 2, epls[p]);
            send(REQ_SWEEP, 0, 0);
        end

        settle();
        $display("Covered %0d request words over %0d register settings in LRU and SLRU modes,",
                 sent, phases);
        $display("including sweeps, ignored keys, full-store evictions and output back-pressure.");
        if (mismatches == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
